FILE: sv/sce_pkg.sv
// Shared types and constants for the system coprocessor exception unit.
package sce_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_ENTER = 2'd2;
    localparam logic [1:0] OP_RFE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_BAD_REG = 2'd2;

    localparam logic [4:0] REG_BPC   = 5'd3;
    localparam logic [4:0] REG_BDA   = 5'd5;
    localparam logic [4:0] REG_JDEST = 5'd6;
    localparam logic [4:0] REG_DCIC  = 5'd7;
    localparam logic [4:0] REG_BADV  = 5'd8;
    localparam logic [4:0] REG_BDAM  = 5'd9;
    localparam logic [4:0] REG_BPCM  = 5'd11;
    localparam logic [4:0] REG_SR    = 5'd12;
    localparam logic [4:0] REG_CAUSE = 5'd13;
    localparam logic [4:0] REG_EPC   = 5'd14;
    localparam logic [4:0] REG_PRID  = 5'd15;

    localparam logic [31:0] PROC_ID    = 32'd2;
    localparam logic [31:0] VEC_BOOT   = 32'hBFC0_0180;
    localparam logic [31:0] VEC_NORMAL = 32'h8000_0080;
    localparam logic [31:0] PC_STEP    = 32'd4;
    localparam int          SR_BEV_BIT = 22;
    localparam int          CAUSE_BD_BIT = 31;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  reg_index;
        logic [31:0] write_value;
        logic [4:0]  exception_code;
        logic [31:0] fault_pc;
        logic        in_delay_slot;
    } in_word_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] handler_address;
        logic [1:0]  access_status;
    } out_word_t;

endpackage

FILE: sv/system_coprocessor_exception_unit.sv
// System coprocessor: status, cause and EPC registers with exception entry and return.
//
// Input channel (in_valid, in_stall, in_word) carries one operation per word:
// register write, register read, exception entry or return from exception.
// Output channel (out_valid, out_stall, out_word) returns exactly one result
// word per input word, in order.
// Structure: input register, then the register update and result logic, then
// the result register. out_valid rises once a word moves from the input
// register into the result register; out_stall can hold that move off.
// Throughput is one word per cycle while the output is not stalled; the status,
// cause and EPC registers are updated in the same cycle a word moves from the
// input register to the result register, so the next word sees the new state.
// When the receiver holds out_stall, the result register holds its word and
// the input register keeps at most one more word; in_stall rises only when
// both are full. Nothing is lost or repeated.
// Reset clears status, cause and EPC to zero and empties both stages.
module system_coprocessor_exception_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sce_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output sce_pkg::out_word_t  out_word
);
    import sce_pkg::*;

    logic        s1_valid_reg;
    in_word_t    s1_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    logic [31:0] status_reg;
    logic [31:0] cause_reg;
    logic [31:0] epc_reg;

    logic [31:0] status_next;
    logic [31:0] cause_next;
    logic [31:0] epc_next;
    out_word_t   result_next;
    logic        advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_comb
    begin
        status_next = status_reg;
        cause_next  = cause_reg;
        epc_next    = epc_reg;
        result_next = '0;
        case (s1_word_reg.mode)
            OP_WRITE:
            begin
                case (s1_word_reg.reg_index) inside
                    REG_BPC, REG_BDA, REG_JDEST, REG_DCIC, REG_BDAM, REG_BPCM:
                        result_next.access_status =
                            (s1_word_reg.write_value != '0) ? ST_IGNORED : ST_OK;
                    REG_SR:
                        status_next = s1_word_reg.write_value;
                    REG_CAUSE:
                        cause_next[9:8] = s1_word_reg.write_value[9:8];
                    default:
                        result_next.access_status = ST_BAD_REG;
                endcase
            end
            OP_READ:
            begin
                case (s1_word_reg.reg_index) inside
                    REG_JDEST, REG_DCIC, REG_BADV:
                        result_next.access_status = ST_IGNORED;
                    REG_SR:    result_next.read_data = status_reg;
                    REG_CAUSE: result_next.read_data = cause_reg;
                    REG_EPC:   result_next.read_data = epc_reg;
                    REG_PRID:  result_next.read_data = PROC_ID;
                    default:
                        result_next.access_status = ST_BAD_REG;
                endcase
            end
            OP_ENTER:
            begin
                // push the kernel/interrupt mode stack by one level
                status_next[5:0] = {status_reg[3:0], 2'b00};
                cause_next[6:2]  = s1_word_reg.exception_code;
                cause_next[CAUSE_BD_BIT] = s1_word_reg.in_delay_slot;
                epc_next = s1_word_reg.in_delay_slot
                         ? s1_word_reg.fault_pc - PC_STEP
                         : s1_word_reg.fault_pc;
                result_next.handler_address =
                    status_reg[SR_BEV_BIT] ? VEC_BOOT : VEC_NORMAL;
            end
            OP_RFE:
            begin
                // pop the mode stack; bits 5:4 keep their value
                status_next[3:0] = status_reg[5:2];
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            cause_reg     <= '0;
            epc_reg       <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                status_reg <= status_next;
                cause_reg  <= cause_next;
                epc_reg    <= epc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_word_reg <= in_word;
        if (advance)
            out_word_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.access_status == ST_OK
                           || out_word_reg.access_status == ST_IGNORED
                           || out_word_reg.access_status == ST_BAD_REG))
        else $error("bad access status");

    a_rfe_keeps_top: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_word_reg.mode == OP_RFE
        |=> status_reg[5:4] == $past(status_reg[5:4]))
        else $error("return from exception changed mode stack top");

    a_enter_vector: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_word_reg.mode == OP_ENTER
        |=> (out_word_reg.handler_address == VEC_BOOT
             || out_word_reg.handler_address == VEC_NORMAL))
        else $error("exception entry without a handler vector");

endmodule
